// ===== rtl/bia_pkg.sv =====
package bia_pkg;

    localparam int FIELD_W     = 14;
    localparam int FIELD_MAX   = (1 << FIELD_W) - 1;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [FIELD_W-1:0] TOTAL_RESET = 14'd8192;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_INODE_TOTAL = 1'b0;
    localparam logic REG_BLOCK_TOTAL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_CLEAR = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    clear;
        logic    req_ready;
        logic    scan_init;
        logic    scan;
        logic    alloc_write;
        logic    free_read;
        logic    free_write;
        logic    fail;
        t_status code;
        logic    load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic accept;
        logic req_alloc;
        logic empty;
        logic range_bad;
        logic hit;
        logic scan_end;
        logic bit_set;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/bia_req_if.sv =====
interface bia_req_if;
    import bia_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic               map_select;
    logic [FIELD_W-1:0] number;

    modport source (output valid, output func, output map_select, output number,
                    input ready);
    modport sink   (input valid, input func, input map_select, input number,
                    output ready);
endinterface

// ===== rtl/bia_rsp_if.sv =====
interface bia_rsp_if;
    import bia_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [FIELD_W-1:0] result_number;
    logic [FIELD_W-1:0] free_count;

    modport source (output valid, output status, output result_number,
                    output free_count, input ready);
    modport sink   (input valid, input status, input result_number,
                    input free_count, output ready);
endinterface

// ===== rtl/bia_ctrl.sv =====
module bia_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bia_pkg::t_stat i_stat,
    output bia_pkg::t_cmd  o_cmd
);
    import bia_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DISP  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_WRITE = 8'b0001_0000,
        S_FRD   = 8'b0010_0000,
        S_FEV   = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.code = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.req_ready = 1'b1;
                if (i_stat.accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                cmd.scan_init = 1'b1;
                priority if (i_stat.req_alloc && i_stat.empty) begin
                    cmd.fail = 1'b1;
                    cmd.code = ST_FULL;
                    n_state  = S_RESP;
                end else if (i_stat.req_alloc) begin
                    n_state = S_SCAN;
                end else if (i_stat.range_bad) begin
                    cmd.fail = 1'b1;
                    cmd.code = ST_RANGE;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                priority if (i_stat.hit) begin
                    n_state = S_WRITE;
                end else if (i_stat.scan_end) begin
                    cmd.fail = 1'b1;
                    cmd.code = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WRITE: begin
                cmd.alloc_write = 1'b1;
                n_state         = S_RESP;
            end
            S_FRD: begin
                cmd.free_read = 1'b1;
                n_state       = S_FEV;
            end
            S_FEV: begin
                if (i_stat.bit_set) begin
                    cmd.free_write = 1'b1;
                end else begin
                    cmd.fail = 1'b1;
                    cmd.code = ST_CLEAR;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

endmodule

// ===== rtl/bia_datapath.sv =====
module bia_datapath #(
    parameter int MAP_BITS = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bia_pkg::FIELD_W-1:0] i_inode_total,
    input  logic [bia_pkg::FIELD_W-1:0] i_block_total,
    input  bia_pkg::t_cmd               i_cmd,
    output bia_pkg::t_stat              o_stat,
    bia_req_if.sink                     i_req,
    bia_rsp_if.source                   o_rsp
);
    import bia_pkg::*;

    localparam int WORDS     = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MAW       = WAW + 1;
    localparam int MEM_DEPTH = 2 ** MAW;
    localparam int CAP       = (MAP_BITS > FIELD_MAX) ? FIELD_MAX : MAP_BITS;

    // request
    logic               r_func;
    logic               r_sel;
    logic [FIELD_W-1:0] r_number;

    // bitmap store: map select is the top address bit
    logic [WORD_W-1:0]  mem [MEM_DEPTH];
    logic [WORD_W-1:0]  r_rdata;
    logic               rd_en;
    logic [MAW-1:0]     rd_addr;
    logic               wr_en;
    logic [MAW-1:0]     wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [MAW-1:0]     r_clr_addr;

    // scan pipeline
    logic [WAW-1:0]     r_rd_word;
    logic [WAW-1:0]     r_ev_word;
    logic               r_ev_valid;
    logic [WORD_W-1:0]  r_hit_data;
    logic [BIT_W-1:0]   r_hit_bit;
    logic [WAW-1:0]     r_hit_word;

    logic [FIELD_W-1:0] r_inode_used;
    logic [FIELD_W-1:0] r_block_used;
    t_status            r_code;
    logic [FIELD_W-1:0] r_res;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [FIELD_W-1:0] r_out_number;
    logic [FIELD_W-1:0] r_out_free;

    logic [FIELD_W-1:0] total_sel;
    logic [FIELD_W-1:0] eff;
    logic [FIELD_W-1:0] used_sel;
    logic [FIELD_W-1:0] free_cnt;
    logic [FIELD_W-1:0] f_idx;
    logic [WAW-1:0]     f_word;
    logic [BIT_W-1:0]   f_bit;
    logic [16:0]        eff_hi;
    logic [16:0]        last_word;
    logic [16:0]        ev_ext;
    logic [16:0]        hit_idx;
    logic [WORD_W-1:0]  cand;
    logic [BIT_W-1:0]   pos;
    logic               found;
    logic               accept;

    // effective total, capped at the map size
    assign total_sel = r_sel ? i_block_total : i_inode_total;
    assign eff       = (total_sel > FIELD_W'(CAP)) ? FIELD_W'(CAP) : total_sel;
    assign used_sel  = r_sel ? r_block_used : r_inode_used;
    assign free_cnt  = (eff > used_sel) ? (eff - used_sel) : '0;

    assign f_idx  = r_number - FIELD_W'(1);
    assign f_word = WAW'(17'(f_idx) >> BIT_W);
    assign f_bit  = f_idx[BIT_W-1:0];

    assign accept      = i_req.valid && i_cmd.req_ready;
    assign i_req.ready = i_cmd.req_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_req.func;
            r_sel    <= i_req.map_select;
            r_number <= i_req.number;
        end
    end

    // lowest clear bit of the evaluated word that lies below the total
    assign eff_hi    = 17'(eff) >> BIT_W;
    assign last_word = 17'(eff - FIELD_W'(1)) >> BIT_W;
    assign ev_ext    = 17'(r_ev_word);

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            cand[b] = ~r_rdata[b] && ((ev_ext < eff_hi) ||
                      ((ev_ext == eff_hi) && (BIT_W'(b) < eff[BIT_W-1:0])));
        end
    end

    always_comb begin
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                pos = BIT_W'(b);
            end
        end
    end

    assign found = |cand;

    // memory ports
    assign rd_en   = i_cmd.scan || i_cmd.free_read;
    assign rd_addr = i_cmd.scan ? {r_sel, r_rd_word} : {r_sel, f_word};
    assign wr_en   = i_cmd.clear || i_cmd.alloc_write || i_cmd.free_write;

    always_comb begin
        priority if (i_cmd.clear) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.alloc_write) begin
            wr_addr = {r_sel, r_hit_word};
            wr_data = r_hit_data | (WORD_W'(1) << r_hit_bit);
        end else begin
            wr_addr = {r_sel, f_word};
            wr_data = r_rdata & ~(WORD_W'(1) << f_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + MAW'(1);
        end
    end

    // read one word ahead of the one under evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_word  <= '0;
            r_ev_word  <= '0;
            r_ev_valid <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_rd_word  <= '0;
            r_ev_valid <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_word  <= r_rd_word + WAW'(1);
            r_ev_word  <= r_rd_word;
            r_ev_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && r_ev_valid && found) begin
            r_hit_data <= r_rdata;
            r_hit_bit  <= pos;
            r_hit_word <= r_ev_word;
        end
    end

    assign hit_idx = (17'(r_hit_word) << BIT_W) | 17'(r_hit_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_used <= '0;
            r_block_used <= '0;
        end else if (i_cmd.alloc_write) begin
            if (r_sel) begin
                r_block_used <= r_block_used + FIELD_W'(1);
            end else begin
                r_inode_used <= r_inode_used + FIELD_W'(1);
            end
        end else if (i_cmd.free_write) begin
            if (r_sel && (r_block_used != '0)) begin
                r_block_used <= r_block_used - FIELD_W'(1);
            end else if (!r_sel && (r_inode_used != '0)) begin
                r_inode_used <= r_inode_used - FIELD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.alloc_write) begin
            r_code <= ST_OK;
            r_res  <= hit_idx[FIELD_W-1:0] + FIELD_W'(1);
        end else if (i_cmd.free_write) begin
            r_code <= ST_OK;
            r_res  <= r_number;
        end else if (i_cmd.fail) begin
            r_code <= i_cmd.code;
            r_res  <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_code;
            r_out_number <= r_res;
            r_out_free   <= free_cnt;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.result_number = r_out_number;
    assign o_rsp.free_count    = r_out_free;

    assign o_stat.clr_last  = (r_clr_addr == MAW'(MEM_DEPTH - 1));
    assign o_stat.accept    = accept;
    assign o_stat.req_alloc = (r_func == FUNC_ALLOC);
    assign o_stat.empty     = (eff == '0);
    assign o_stat.range_bad = (r_number == '0) || (r_number > eff);
    assign o_stat.hit       = r_ev_valid && found;
    assign o_stat.scan_end  = r_ev_valid && !found && (ev_ext == last_word);
    assign o_stat.bit_set   = r_rdata[f_bit];
    assign o_stat.out_free  = !r_out_valid || o_rsp.ready;

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// Channel   Dir  Handshake            Beat carries
// i_req     in   valid / ready        func, map_select, number
// o_rsp     out  valid / ready        status, result_number, free_count
// apb       in   psel/penable/pready  inode_total at 0x0, block_total at 0x4
//
// Allocate: dispatch, then a scan of the bitmap RAM from word 0 up to the 64-bit
// word that holds the lowest free bit, then write and respond. The scan reads one
// word of the bitmap RAM per cycle. Free: dispatch, read, modify and write, respond;
// a rejected number or an empty map goes from dispatch straight to respond.
// After reset a clearing pass writes all 2 * 2**clog2(MAP_BITS/64) RAM rows (256 at
// 8192 bits); no request is taken until it ends.
// A waiting result sits in the output register; the next request is still taken.
module bitmap_id_allocator #(
    parameter int MAP_BITS = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bia_req_if.sink                     i_req,
    bia_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bia_pkg::APB_AW-1:0]  paddr,
    input  logic [bia_pkg::APB_DW-1:0]  pwdata,
    output logic [bia_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bia_pkg::*;

    logic [FIELD_W-1:0] r_inode_total;
    logic [FIELD_W-1:0] r_block_total;
    logic               cfg_wr;
    t_cmd               cmd;
    t_stat              stat;

    // Register file: take the write on the access phase, decode on word index
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_total <= TOTAL_RESET;
            r_block_total <= TOTAL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_INODE_TOTAL: r_inode_total <= pwdata[FIELD_W-1:0];
                REG_BLOCK_TOTAL: r_block_total <= pwdata[FIELD_W-1:0];
                default:         r_inode_total <= r_inode_total;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INODE_TOTAL: prdata = APB_DW'(r_inode_total);
            REG_BLOCK_TOTAL: prdata = APB_DW'(r_block_total);
            default:         prdata = '0;
        endcase
    end

    // Sequencer: clear, dispatch, scan or read-modify-write, respond
    bia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Bitmap RAM, scan logic, used counters and output register
    bia_datapath #(
        .MAP_BITS (MAP_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_inode_total (r_inode_total),
        .i_block_total (r_block_total),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req         (i_req),
        .o_rsp         (o_rsp)
    );

endmodule

// ===== bench/bitmap_id_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_id_allocator_tb;
    import bia_pkg::*;

    localparam int MAP_SIZE      = 8192;
    // Settling time after the last beat, rounded up from the longest allocate scan.
    localparam int SETTLE_CYCLES = 140;
    // Slowest correct run, taken several times over.
    localparam int CYCLE_LIMIT   = 1000000;

    // One answer from the allocator, as the bitmap shadow predicts it.
    typedef struct {
        t_status            status;
        logic [FIELD_W-1:0] number;
        logic [FIELD_W-1:0] free_left;
    } t_grant;

    // Shadow copy of both usage bitmaps, their counters and totals. Each
    // accepted request updates the shadow and queues the answer it owes.
    class t_bitmap_tracker;
        bit     bitmap [2][MAP_SIZE];
        int     used [2];
        int     total [2];
        t_grant replies_due [$];
        int     errors;

        function new();
            total[0] = int'(TOTAL_RESET);
            total[1] = int'(TOTAL_RESET);
        endfunction

        // Totals above the map size are clipped to it.
        function int span(logic sel);
            return (total[sel] > MAP_SIZE) ? MAP_SIZE : total[sel];
        endfunction

        function void set_total(logic idx, logic [FIELD_W-1:0] value);
            total[idx] = int'(value);
        endfunction

        function void note_request(logic func, logic sel, logic [FIELD_W-1:0] num);
            t_grant g;
            int     cap;
            int     i;
            cap         = span(sel);
            g.status    = ST_OK;
            g.number    = '0;
            if (func == FUNC_ALLOC) begin
                g.status = ST_FULL;
                for (i = 0; i < cap; i++) begin
                    if (!bitmap[sel][i]) begin
                        bitmap[sel][i] = 1'b1;
                        used[sel]++;
                        g.status = ST_OK;
                        g.number = FIELD_W'(i + 1);
                        break;
                    end
                end
            end else if (num == 0 || num > cap) begin
                g.status = ST_RANGE;
            end else if (!bitmap[sel][num - 1]) begin
                g.status = ST_CLEAR;
            end else begin
                bitmap[sel][num - 1] = 1'b0;
                if (used[sel] > 0)
                    used[sel]--;
                g.number = num;
            end
            g.free_left = (cap > used[sel]) ? FIELD_W'(cap - used[sel]) : '0;
            replies_due.push_back(g);
        endfunction

        function void check_response(logic [1:0] status, logic [FIELD_W-1:0] num,
                                     logic [FIELD_W-1:0] free_left);
            t_grant g;
            if (replies_due.size() == 0) begin
                $error("unexpected beat: status %0d result_number %0d free_count %0d",
                       status, num, free_left);
                errors++;
                return;
            end
            g = replies_due.pop_front();
            if (status !== g.status) begin
                $error("status: expected %0d, got %0d", g.status, status);
                errors++;
            end
            if (num !== g.number) begin
                $error("result_number: expected %0d, got %0d", g.number, num);
                errors++;
            end
            if (free_left !== g.free_left) begin
                $error("free_count: expected %0d, got %0d", g.free_left, free_left);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    bia_req_if req_if ();
    bia_rsp_if rsp_if ();

    t_bitmap_tracker tracker = new();

    // Idle odds in percent for each side, and a hold-off count that
    // the response side burns down on its own.
    int          req_idle_pct;
    int          rsp_idle_pct;
    int          rsp_hold;
    int unsigned cycle_cnt;

    bitmap_id_allocator #(
        .MAP_BITS (MAP_SIZE)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing beat ends the run here.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Response side: pick ready at the falling edge, take the beat at the
    // rising edge. A hold-off keeps ready low for a counted stretch so the
    // result register fills and the request side backs up.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rsp_hold > 0) begin
                rsp_if.ready = 1'b0;
                rsp_hold--;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                tracker.check_response(rsp_if.status, rsp_if.result_number,
                                       rsp_if.free_count);
        end
    end

    // Offer one request beat, with random idle cycles ahead of it. Valid is
    // left high after the beat so the next call can follow back to back.
    task automatic send_request(input logic func, input logic sel,
                                input logic [FIELD_W-1:0] num);
        while ($urandom_range(99) < req_idle_pct) begin
            @(negedge clk);
            req_if.valid = 1'b0;
        end
        @(negedge clk);
        req_if.valid      = 1'b1;
        req_if.func       = func;
        req_if.map_select = sel;
        req_if.number     = num;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        tracker.note_request(func, sel, num);
    endtask

    // Drop valid, wait for every owed beat, then let the block settle.
    task automatic drain_replies();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (tracker.replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup, then access until pready. A read is compared
    // with the shadow register.
    task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (wr) begin
            tracker.set_total(idx, wdata[FIELD_W-1:0]);
        end else if (prdata !== APB_DW'(tracker.total[idx])) begin
            $error("prdata: expected %0d, got %0d", tracker.total[idx], prdata);
            tracker.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Reprogram both totals with the block idle, and read them back.
    task automatic program_totals(input logic [APB_DW-1:0] inode_val,
                                  input logic [APB_DW-1:0] block_val);
        drain_replies();
        apb_access(1'b1, REG_INODE_TOTAL, inode_val);
        apb_access(1'b1, REG_BLOCK_TOTAL, block_val);
        apb_access(1'b0, REG_INODE_TOTAL, '0);
        apb_access(1'b0, REG_BLOCK_TOTAL, '0);
    endtask

    // Mostly well-formed traffic: allocations, and frees aimed at the dense
    // low end where first-fit has set bits. The rest is out-of-range noise
    // and the boundary numbers zero, total and total plus one.
    task automatic random_requests(input int alloc_pct, input int count);
        logic               func;
        logic               sel;
        logic [FIELD_W-1:0] num;
        int                 cap;
        int                 pick;
        repeat (count) begin
            sel  = 1'($urandom_range(1));
            num  = FIELD_W'($urandom);
            cap  = tracker.span(sel);
            func = FUNC_FREE;
            if ($urandom_range(99) < alloc_pct) begin
                func = FUNC_ALLOC;
            end else begin
                pick = int'($urandom_range(9));
                if (pick < 6) begin
                    num = FIELD_W'($urandom_range(tracker.used[sel] + 3, 1));
                end else if (pick == 9) begin
                    case ($urandom_range(2))
                        0:       num = '0;
                        1:       num = FIELD_W'(cap);
                        default: num = FIELD_W'(cap + 1);
                    endcase
                end
            end
            send_request(func, sel, num);
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_ALLOC;
        req_if.map_select = 1'b0;
        req_if.number     = '0;
        rsp_hold          = 0;
        req_idle_pct      = 27;
        rsp_idle_pct      = 57;

        // Hold reset low, then release it on a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Tiny inode map to hit full quickly; block total all ones on the
        // bus, which masks to 16383 and clips to the map size.
        program_totals(3, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 1'b0, '0);
        send_request(FUNC_ALLOC, 1'b0, 14'h3FFF);
        send_request(FUNC_ALLOC, 1'b0, '0);
        send_request(FUNC_ALLOC, 1'b0, '0);         // map full
        send_request(FUNC_ALLOC, 1'b1, '0);
        send_request(FUNC_ALLOC, 1'b1, '0);
        send_request(FUNC_FREE,  1'b0, 14'd0);      // zero is out of range
        send_request(FUNC_FREE,  1'b0, 14'd4);      // above the total
        send_request(FUNC_FREE,  1'b0, 14'd2);
        send_request(FUNC_FREE,  1'b0, 14'd2);      // already free
        send_request(FUNC_ALLOC, 1'b0, '0);         // refills the hole
        send_request(FUNC_FREE,  1'b1, 14'd8192);   // last number, clear bit
        send_request(FUNC_FREE,  1'b1, 14'd8193);
        send_request(FUNC_FREE,  1'b1, 14'h3FFF);
        send_request(FUNC_FREE,  1'b1, 14'd1);

        // Lower the inode total under its set bits; block total zero.
        program_totals(1, 0);
        send_request(FUNC_ALLOC, 1'b1, '0);         // zero total reads as full
        send_request(FUNC_FREE,  1'b1, 14'd1);
        send_request(FUNC_ALLOC, 1'b0, '0);         // used above total
        send_request(FUNC_FREE,  1'b0, 14'd3);      // stranded bit
        send_request(FUNC_FREE,  1'b0, 14'd1);
        send_request(FUNC_ALLOC, 1'b0, '0);

        // Back to the full map: stranded bits come into reach again.
        program_totals(8192, 8192);
        send_request(FUNC_FREE,  1'b0, 14'd3);
        send_request(FUNC_ALLOC, 1'b0, '0);
        send_request(FUNC_ALLOC, 1'b0, '0);
        send_request(FUNC_FREE,  1'b1, 14'd2);

        // Random traffic: sender idles less than the receiver.
        program_totals(70, 130);
        random_requests(60, 135);

        // Deep inode map; mid-phase the receiver holds off for a long
        // stretch while requests keep coming.
        program_totals(8192, 64);
        random_requests(85, 20);
        rsp_hold = 400;
        random_requests(85, 115);

        // Swap the idle odds.
        req_idle_pct = 57;
        rsp_idle_pct = 27;
        program_totals(200, 1);
        random_requests(60, 135);

        // Pause the sender halfway until every beat is back.
        program_totals(0, 8191);
        random_requests(55, 70);
        drain_replies();
        random_requests(55, 65);

        // No idling at all from here.
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        program_totals(129, 40);
        random_requests(60, 135);

        // Upper bits of the write data must be dropped: inode total 100.
        program_totals(32'hFFFF_C064, 8192);
        random_requests(60, 130);

        drain_replies();
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bia_pkg.sv
rtl/bia_req_if.sv
rtl/bia_rsp_if.sv
rtl/bia_ctrl.sv
rtl/bia_datapath.sv
rtl/bitmap_id_allocator.sv
bench/bitmap_id_allocator_tb.sv
